/* src/interrupt_event_waiter_dispatch_core_defines.svh */
// ----------------------------------------------------------------------------
// Event waiter dispatch - assertion macros
// Shared assertion helpers, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_EVENT_WAITER_DISPATCH_CORE_DEFINES_SVH
`define INTERRUPT_EVENT_WAITER_DISPATCH_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define EWD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define EWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ewd_pkg.sv */
// ----------------------------------------------------------------------------
// Event waiter dispatch - package
// Item types, event and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package ewd_pkg;

  localparam int TASK_ID_BITS = 6;
  localparam int EVENT_COUNT  = 5;
  localparam int EVENT_BITS   = 3;

  localparam logic [EVENT_BITS-1:0] EV_TIMER = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_RX1   = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_TX1   = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_RX2   = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_TX2   = 3'd4;

  localparam logic OP_AWAIT = 1'b0;
  localparam logic OP_IRQ   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_NOSRC = 2'd2;

  localparam logic CTS_AT_START_RST = 1'b0;

  typedef struct packed {
    logic                    opcode;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [EVENT_BITS-1:0]   event_number;
    logic                    timer_pending;
    logic                    uart2_pending;
    logic                    uart1_pending;
    logic                    uart2_tx_flag;
    logic                    uart2_rx_flag;
    logic                    uart1_tx_flag;
    logic                    uart1_modem_flag;
    logic                    uart1_rx_flag;
    logic                    cts_level;
  } in_item_t;

  typedef struct packed {
    logic                    woke;
    logic [TASK_ID_BITS-1:0] woken_task;
    logic [EVENT_BITS-1:0]   woken_event;
    logic [1:0]              status;
    logic [EVENT_COUNT-1:0]  enabled_events;
    logic                    last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic sel_second;
  } ewd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic two_results;
  } ewd_stat_t;

endpackage

/* src/ewd_ctrl.sv */
// ----------------------------------------------------------------------------
// Event waiter dispatch - controller
// Sequences one item: accept, then hand out one or two results.
// ----------------------------------------------------------------------------
module ewd_ctrl import ewd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ewd_stat_t stat,
  output ewd_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OUT0 = 2'd1;
  localparam logic [1:0] S_OUT1 = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign cmd.load       = in_valid && in_ready;
  assign cmd.sel_second = (state_r == S_OUT1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_OUT0;
      end
      S_OUT0: begin
        if (out_ready) state_nxt = stat.two_results ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* src/ewd_datapath.sv */
// ----------------------------------------------------------------------------
// Event waiter dispatch - datapath
// Waiter slots, enable bits, serial-1 handshake flags and result registers.
// ----------------------------------------------------------------------------
module ewd_datapath import ewd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ewd_cmd_t  cmd,
  output ewd_stat_t stat,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output out_item_t out_data
);

  typedef struct packed {
    logic                    woke;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [EVENT_BITS-1:0]   ev;
  } res_t;

  logic [TASK_ID_BITS-1:0] waiter_task_r [EVENT_COUNT];
  logic [EVENT_COUNT-1:0]  waiter_valid_r, waiter_valid_nxt;
  logic [EVENT_COUNT-1:0]  enable_r, enable_nxt;
  logic                    cts_r, cts_nxt;
  logic                    txrdy_r, txrdy_nxt;
  logic [1:0]              status_r, status_nxt;
  logic                    two_r, two_nxt;
  res_t                    res0_r, res0_nxt;
  res_t                    res1_r, res1_nxt;
  res_t                    cand [EVENT_COUNT];
  logic                    slot_wr;
  logic                    cts_mid, txrdy_mid;
  res_t                    res_sel;

  // what serving each slot would report; unwritten tasks are masked off
  always_comb begin
    for (int e = 0; e < EVENT_COUNT; e++) begin
      cand[e].woke    = waiter_valid_r[e];
      cand[e].task_id = waiter_valid_r[e] ? waiter_task_r[e] : '0;
      cand[e].ev      = EVENT_BITS'(e);
    end
  end

  always_comb begin
    waiter_valid_nxt = waiter_valid_r;
    enable_nxt       = enable_r;
    cts_nxt          = cts_r;
    txrdy_nxt        = txrdy_r;
    status_nxt       = ST_OK;
    two_nxt          = 1'b0;
    res0_nxt         = '0;
    res1_nxt         = '0;
    slot_wr          = 1'b0;
    cts_mid          = cts_r;
    txrdy_mid        = txrdy_r;
    if (in_data.opcode == OP_AWAIT) begin
      if (in_data.event_number < EVENT_BITS'(EVENT_COUNT) &&
          !waiter_valid_r[in_data.event_number]) begin
        slot_wr                                = 1'b1;
        waiter_valid_nxt[in_data.event_number] = 1'b1;
        enable_nxt[in_data.event_number]       = 1'b1;
      end else begin
        status_nxt = ST_BAD;
      end
    end else if (in_data.timer_pending) begin
      res0_nxt                   = cand[EV_TIMER];
      waiter_valid_nxt[EV_TIMER] = 1'b0;
      enable_nxt[EV_TIMER]       = 1'b0;
    end else if (in_data.uart2_pending) begin
      if (in_data.uart2_tx_flag) begin
        res0_nxt                 = cand[EV_TX2];
        waiter_valid_nxt[EV_TX2] = 1'b0;
        enable_nxt[EV_TX2]       = 1'b0;
      end
      if (in_data.uart2_rx_flag) begin
        if (in_data.uart2_tx_flag) begin
          res1_nxt = cand[EV_RX2];
          two_nxt  = 1'b1;
        end else begin
          res0_nxt = cand[EV_RX2];
        end
        waiter_valid_nxt[EV_RX2] = 1'b0;
        enable_nxt[EV_RX2]       = 1'b0;
      end
    end else if (in_data.uart1_pending) begin
      if (in_data.uart1_tx_flag) begin
        txrdy_mid          = 1'b1;
        enable_nxt[EV_TX1] = 1'b0;
      end
      if (in_data.uart1_modem_flag) cts_mid = in_data.cts_level;
      if (in_data.uart1_rx_flag) begin
        res0_nxt                 = cand[EV_RX1];
        waiter_valid_nxt[EV_RX1] = 1'b0;
        enable_nxt[EV_RX1]       = 1'b0;
      end
      // transmit waiter released only with both ready and clear-to-send;
      // its enable bit is left alone here
      if (cts_mid && txrdy_mid) begin
        if (in_data.uart1_rx_flag) begin
          res1_nxt = cand[EV_TX1];
          two_nxt  = 1'b1;
        end else begin
          res0_nxt = cand[EV_TX1];
        end
        waiter_valid_nxt[EV_TX1] = 1'b0;
        txrdy_mid                = 1'b0;
        cts_mid                  = 1'b0;
      end
      cts_nxt   = cts_mid;
      txrdy_nxt = txrdy_mid;
    end else begin
      status_nxt = ST_NOSRC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiter_valid_r <= '0;
      enable_r       <= '0;
      cts_r          <= CTS_AT_START_RST;
      txrdy_r        <= 1'b0;
    end else if (cmd.load) begin
      waiter_valid_r <= waiter_valid_nxt;
      enable_r       <= enable_nxt;
      cts_r          <= cts_nxt;
      txrdy_r        <= txrdy_nxt;
    end else if (cfg_valid) begin
      cts_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (slot_wr) waiter_task_r[in_data.event_number] <= in_data.task_id;
      res0_r   <= res0_nxt;
      res1_r   <= res1_nxt;
      status_r <= status_nxt;
      two_r    <= two_nxt;
    end
  end

  assign stat.two_results = two_r;
  assign res_sel          = cmd.sel_second ? res1_r : res0_r;

  assign out_data.woke           = res_sel.woke;
  assign out_data.woken_task     = res_sel.task_id;
  assign out_data.woken_event    = res_sel.ev;
  assign out_data.status         = status_r;
  assign out_data.enabled_events = enable_r;
  assign out_data.last           = cmd.sel_second || !two_r;

endmodule

/* src/interrupt_event_waiter_dispatch_core.sv */
// ----------------------------------------------------------------------------
// Event waiter dispatch core
// One waiter slot per event (timer, serial 1/2 rx/tx); await and interrupt
// items claim slots or wake waiting tasks.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per await call or interrupt arrival (valid/ready).
//   out_* : one or two results per item, the final one flagged by last.
//   cfg_* : single register, clear-to-send level; write only while idle.
//           cfg_ready is always high.
// Timing: an item is taken while the controller is idle; its first result is
//   shown in the cycle after it is taken, a second result once the first is taken.
//   The controller holds a single item in flight: no new item is taken until
//   the last result of the current item has been accepted.
// Reset clears all slots, enable bits and the serial-1 flags; clear-to-send
//   comes back at its reset level. When the receiver stalls the result is
//   held in the output registers and no new item is taken.
// ----------------------------------------------------------------------------
module interrupt_event_waiter_dispatch_core import ewd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  ewd_cmd_t  cmd;
  ewd_stat_t stat;

  assign cfg_ready = 1'b1;

  ewd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ewd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* src/ewd_checker.sv */
// ----------------------------------------------------------------------------
// Event waiter dispatch - port checker
// Watches the top-level ports over time; bound to the core.
// ----------------------------------------------------------------------------
`include "interrupt_event_waiter_dispatch_core_defines.svh"

module ewd_checker import ewd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `EWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed under stall")

  `EWD_ASSERT_SAME(a_one_in_flight, in_ready, !out_valid, "item taken while a result is pending")

  `EWD_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted item gave no result")

  `EWD_ASSERT_NEXT(a_second_result, out_valid && out_ready && !out_data.last, out_valid, "second result missing")

  `EWD_ASSERT_SAME(a_no_task_unwoken, out_valid && !out_data.woke, out_data.woken_task == '0, "task shown without a wake")

endmodule

bind interrupt_event_waiter_dispatch_core ewd_checker u_ewd_checker (.*);
